/* hdl/swm_pkg.sv */
// ----------------------------------------------------------------------------
// Sliding-window median package
// Shared sizes and the record types that pass between neighbouring cells of
// the sorted cell row.
// ----------------------------------------------------------------------------
package swm_pkg;

	// Largest window and sample width.
	localparam int MAX_WINDOW  = 32;
	localparam int SAMPLE_BITS = 32;

	// Width of the window length register.
	localparam int WLEN_BITS = 6;

	// Age of a sample within the window, and the fill count (0 to MAX_WINDOW).
	localparam int AGE_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int COUNT_W = $clog2(MAX_WINDOW + 1);

	// Window length after reset.
	localparam logic [WLEN_BITS-1:0] WLEN_RESET = WLEN_BITS'(3);

	// Contents of one cell of the sorted row.
	typedef struct packed {
		logic                   valid;
		logic [SAMPLE_BITS-1:0] val;
		logic [AGE_W-1:0]       age;
	} cell_t;

	// Passed upwards: removal seen at or below, and the row after removal.
	typedef struct packed {
		logic  rb;
		logic  gt_post;
		cell_t post;
	} up_link_t;

	// Passed downwards: a cell's current contents and its comparison.
	typedef struct packed {
		logic  gt;
		cell_t cur;
	} dn_link_t;

endpackage

/* hdl/sliding_window_median.sv */
// ----------------------------------------------------------------------------
// Sliding-window median filter
// Keeps the most recent window_len samples in a sorted row of cells and
// returns the lower median of every full window.
// ----------------------------------------------------------------------------
// The filter accepts one sample per clock cycle while sample_stall is low.
// The sorted row of cells removes the oldest sample and inserts the new one
// at the accepting edge, and an output register then picks the middle cell
// once the output is free. A result is given only once window_len samples
// are held (window_len of 0 acts as 1, above 32 as 32); a restart flag or a
// write of window_len empties the window.
// Back-pressure on the result side stalls the sample side only while a
// result waits behind a full output.
module sliding_window_median (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [swm_pkg::WLEN_BITS-1:0]     window_len,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  logic [swm_pkg::SAMPLE_BITS-1:0]   sample,
	input  logic                              restart,
	output logic                              median_valid,
	input  logic                              median_stall,
	output logic [swm_pkg::SAMPLE_BITS-1:0]   median
);
	import swm_pkg::*;

	logic [WLEN_BITS-1:0]   window_len_q;
	logic [COUNT_W-1:0]     fill_q;
	logic                   result_s1;
	logic                   median_valid_q;
	logic [SAMPLE_BITS-1:0] median_q;

	logic [COUNT_W-1:0]     w_eff;
	logic [AGE_W-1:0]       oldest_age;
	logic [AGE_W-1:0]       mid;
	logic [COUNT_W-1:0]     fill_eff;
	logic [COUNT_W-1:0]     fill_next;
	logic                   kill;
	logic                   full;
	logic                   emit;
	logic                   out_free;
	logic                   step;
	logic                   cfg_wr;
	logic [SAMPLE_BITS-1:0] pick;

	up_link_t up_link [MAX_WINDOW+1];
	dn_link_t dn_link [MAX_WINDOW+1];
	cell_t    cell_st [MAX_WINDOW];

	// Handshakes.
	assign cfg_ready    = 1'b1;
	assign cfg_wr       = cfg_valid & cfg_ready;
	assign out_free     = !median_valid_q || !median_stall;
	assign sample_stall = result_s1 && !out_free;
	assign step         = sample_valid && !sample_stall;
	assign median_valid = median_valid_q;
	assign median       = median_q;

	// Effective window length and the derived ages and positions.
	always_comb begin
		if (window_len_q == '0) begin
			w_eff = COUNT_W'(1);
		end else if (int'(window_len_q) > MAX_WINDOW) begin
			w_eff = COUNT_W'(MAX_WINDOW);
		end else begin
			w_eff = COUNT_W'(window_len_q);
		end
	end
	assign oldest_age = AGE_W'(w_eff - COUNT_W'(1));
	assign mid        = AGE_W'((w_eff - COUNT_W'(1)) >> 1);

	// Fill count for this transaction.
	assign kill      = restart || (fill_q > w_eff);
	assign fill_eff  = kill ? '0 : fill_q;
	assign full      = (fill_eff == w_eff);
	assign fill_next = full ? fill_eff : fill_eff + COUNT_W'(1);
	assign emit      = (fill_next == w_eff);

	// Ends of the cell row.
	assign up_link[0].rb           = 1'b0;
	assign up_link[0].gt_post      = 1'b0;
	assign up_link[0].post         = '0;
	assign dn_link[MAX_WINDOW].gt  = 1'b1;
	assign dn_link[MAX_WINDOW].cur = '0;

	// The sorted row, lowest value in cell 0.
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		swm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.step       (step),
			.wipe       (cfg_wr),
			.kill       (kill),
			.full       (full),
			.oldest_age (oldest_age),
			.sample_in  (sample),
			.from_below (up_link[i]),
			.from_above (dn_link[i+1]),
			.to_above   (up_link[i+1]),
			.to_below   (dn_link[i]),
			.state      (cell_st[i])
		);
	end

	// Middle cell of the window.
	always_comb begin
		pick = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (mid == AGE_W'(i)) begin
				pick = pick | cell_st[i].val;
			end
		end
	end

	// Window length and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WLEN_RESET;
			fill_q       <= '0;
		end else if (cfg_wr) begin
			window_len_q <= window_len;
			fill_q       <= '0;
		end else if (step) begin
			fill_q <= fill_next;
		end
	end

	// Result pending in the cell row, then the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_s1      <= 1'b0;
			median_valid_q <= 1'b0;
		end else begin
			if (step) begin
				result_s1 <= emit;
			end else if (result_s1 && out_free) begin
				result_s1 <= 1'b0;
			end
			if (result_s1 && out_free) begin
				median_valid_q <= 1'b1;
			end else if (!median_stall) begin
				median_valid_q <= 1'b0;
			end
		end
	end

	// Median value of the finished transaction.
	always_ff @(posedge clk) begin
		if (result_s1 && out_free) begin
			median_q <= pick;
		end
	end

endmodule

/* hdl/swm_cell.sv */
// ----------------------------------------------------------------------------
// Sorted row cell
// Holds one sample of the window with its age. On each transaction the cell
// takes part in removing the oldest sample and inserting the new one, using
// only its own contents and those of its two neighbours.
// ----------------------------------------------------------------------------
module swm_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic                              wipe,
	input  logic                              kill,
	input  logic                              full,
	input  logic [swm_pkg::AGE_W-1:0]         oldest_age,
	input  logic [swm_pkg::SAMPLE_BITS-1:0]   sample_in,
	input  swm_pkg::up_link_t                 from_below,
	input  swm_pkg::dn_link_t                 from_above,
	output swm_pkg::up_link_t                 to_above,
	output swm_pkg::dn_link_t                 to_below,
	output swm_pkg::cell_t                    state
);
	import swm_pkg::*;

	logic             valid_q;
	logic [SAMPLE_BITS-1:0] val_q;
	logic [AGE_W-1:0] age_q;

	cell_t eff;
	cell_t post;
	cell_t nxt;
	logic  gt;
	logic  rm;
	logic  rb;
	logic  gt_post;

	// Current contents; a restart, or a fill count above the window length, empties the row for this transaction.
	always_comb begin
		eff.valid = valid_q & ~kill;
		eff.val   = val_q;
		eff.age   = age_q;
	end

	// An empty cell sorts above every sample.
	assign gt = !eff.valid || ($signed(eff.val) > $signed(sample_in));

	// The oldest sample leaves once the window is full.
	assign rm = eff.valid && full && (eff.age == oldest_age);
	assign rb = from_below.rb | rm;

	// Row after removal: cells at or above the removed one close the gap.
	assign post    = rb ? from_above.cur : eff;
	assign gt_post = rb ? from_above.gt : gt;

	assign to_above.rb      = rb;
	assign to_above.gt_post = gt_post;
	assign to_above.post    = post;
	assign to_below.gt      = gt;
	assign to_below.cur     = eff;
	assign state.valid      = valid_q;
	assign state.val        = val_q;
	assign state.age        = age_q;

	// Insertion: shift up above the new sample, take it at its place.
	always_comb begin
		if (from_below.gt_post) begin
			nxt     = from_below.post;
			nxt.age = from_below.post.age + AGE_W'(from_below.post.valid);
		end else if (gt_post) begin
			nxt.valid = 1'b1;
			nxt.val   = sample_in;
			nxt.age   = '0;
		end else begin
			nxt     = post;
			nxt.age = post.age + AGE_W'(post.valid);
		end
	end

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wipe) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= nxt.valid;
		end
	end

	// Sample and age.
	always_ff @(posedge clk) begin
		if (step) begin
			val_q <= nxt.val;
			age_q <= nxt.age;
		end
	end

endmodule

/* tb/sv/sliding_window_median_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding-window median filter testbench
// Streams signed samples through the filter under random idling on both
// sides. Each accepted sample is fed to a behavioural window model, and every
// median that leaves the filter is compared with the oldest predicted one.
// ----------------------------------------------------------------------------
module sliding_window_median_tb;

	import swm_pkg::*;

	typedef struct {
		logic [SAMPLE_BITS-1:0] value;
		logic                   restart;
	} sample_txn_t;

	localparam int NUM_PHASES    = 15;
	localparam int PHASE_SAMPLES = 60;
	localparam int HOLDOFF_LEN   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 50000;

	// Block ports; every input starts at a known value.
	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [WLEN_BITS-1:0]   window_len   = '0;
	logic                   sample_valid = 1'b0;
	logic                   sample_stall;
	logic [SAMPLE_BITS-1:0] sample       = '0;
	logic                   restart      = 1'b0;
	logic                   median_valid;
	logic                   median_stall = 1'b0;
	logic [SAMPLE_BITS-1:0] median;

	// Stimulus and scoreboard storage.
	sample_txn_t                   pending_samples[$];
	sample_txn_t                   next_txn;
	logic signed [SAMPLE_BITS-1:0] expected_medians[$];
	logic signed [SAMPLE_BITS-1:0] expected_front;

	// Window model: samples in arrival order and the same samples sorted.
	logic signed [SAMPLE_BITS-1:0] window_fifo[$];
	logic signed [SAMPLE_BITS-1:0] window_sorted[$];
	logic [WLEN_BITS-1:0]          model_wlen = WLEN_RESET;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int holdoff_requests = 0;
	int holdoff_served = 0;
	int holdoff_left = 0;
	int error_count = 0;
	int samples_accepted = 0;
	int medians_checked = 0;
	int settings_used = 1;

	sliding_window_median i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.window_len   (window_len),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.restart      (restart),
		.median_valid (median_valid),
		.median_stall (median_stall),
		.median       (median)
	);

	// Clock generation.
	initial begin
		forever #2 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#2000000;
		$display("Timeout: the filter stopped making progress.");
		$display("Test completed with failures");
		$finish;
	end

	// Advances the window model by one sample and records the median, if any.
	task automatic predict_median(input logic signed [SAMPLE_BITS-1:0] value,
			input logic clear);
		int                            eff_len;
		int                            pos;
		logic signed [SAMPLE_BITS-1:0] oldest;
		eff_len = (model_wlen == 0) ? 1 :
			((model_wlen > MAX_WINDOW) ? MAX_WINDOW : int'(model_wlen));
		if (clear) begin
			window_fifo.delete();
			window_sorted.delete();
		end
		// A full window drops its oldest sample, one copy of it in sorted order.
		if (window_fifo.size() == eff_len) begin
			oldest = window_fifo.pop_front();
			pos = 0;
			while (window_sorted[pos] != oldest)
				pos++;
			window_sorted.delete(pos);
		end
		window_fifo.insert(window_fifo.size(), value);
		pos = 0;
		while (pos < window_sorted.size() && window_sorted[pos] <= value)
			pos++;
		window_sorted.insert(pos, value);
		if (window_fifo.size() == eff_len)
			expected_medians.insert(expected_medians.size(),
				window_sorted[(eff_len - 1) / 2]);
	endtask

	task automatic report_failure(input string what, input logic [SAMPLE_BITS-1:0] exp_val,
			input logic [SAMPLE_BITS-1:0] act_val);
		error_count++;
		if (error_count <= 10)
			$display("%t: %s: expected %0d (0x%08h), got %0d (0x%08h)", $realtime, what,
				$signed(exp_val), exp_val, $signed(act_val), act_val);
	endtask

	// Sample driver: the model is advanced on every accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			if (sample_valid && !sample_stall) begin
				predict_median(sample, restart);
				samples_accepted++;
			end
			if (!sample_valid || !sample_stall) begin
				if (pending_samples.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					next_txn = pending_samples.pop_front();
					sample_valid <= 1'b1;
					sample <= next_txn.value;
					restart <= next_txn.restart;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here so that the back-pressure reaches the input.
	always @(posedge clk) begin
		if (holdoff_served != holdoff_requests) begin
			holdoff_served <= holdoff_served + 1;
			holdoff_left <= HOLDOFF_LEN;
		end else if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
		end
	end

	// Result monitor and receiver stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			median_stall <= 1'b0;
		end else begin
			if (median_valid && !median_stall) begin
				if (expected_medians.size() == 0) begin
					report_failure("median with no sample to explain it", '0, median);
				end else begin
					expected_front = expected_medians.pop_front();
					medians_checked++;
					if (median !== expected_front)
						report_failure("median mismatch", expected_front, median);
				end
			end
			median_stall <= (holdoff_left != 0) || ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	task automatic queue_sample(input logic [SAMPLE_BITS-1:0] value, input logic clear);
		sample_txn_t txn;
		txn.value = value;
		txn.restart = clear;
		pending_samples.insert(pending_samples.size(), txn);
	endtask

	// Mostly full-range values, with extremes and a narrow band that forces duplicates.
	function automatic logic [SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2, 3: return $urandom_range(0, 8) - 4;
			default: return $urandom;
		endcase
	endfunction

	// Waits until every sample is accepted and every median has left the filter.
	task automatic wait_drained();
		int guard;
		guard = 0;
		while ((pending_samples.size() != 0 || sample_valid || expected_medians.size() != 0)
				&& guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the window length while the filter is idle; the window empties.
	task automatic write_window_len(input logic [WLEN_BITS-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		window_len <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		model_wlen = value;
		window_fifo.delete();
		window_sorted.delete();
		settings_used++;
	endtask

	// Main sequence.
	initial begin
		int phase_wlen[NUM_PHASES];
		int n;
		phase_wlen = '{5, 1, 32, 4, 63, 2, 7, 16, 33, 3, 31, 8, 0, 6, 20};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset window of three, extremes, duplicates and a restart.
		queue_sample(32'h7fff_ffff, 1'b0);
		queue_sample(32'h8000_0000, 1'b0);
		queue_sample(32'h0000_0000, 1'b0);
		queue_sample(32'hffff_ffff, 1'b0);
		queue_sample(32'h0000_0001, 1'b0);
		queue_sample(32'h8000_0000, 1'b0);
		queue_sample(32'h8000_0000, 1'b0);
		queue_sample(32'h7fff_ffff, 1'b0);
		queue_sample(32'h0000_0005, 1'b0);
		queue_sample(32'h0000_0005, 1'b0);
		queue_sample(32'h0000_0005, 1'b0);
		queue_sample(32'h0000_0009, 1'b1);
		queue_sample(32'h0000_0002, 1'b0);
		queue_sample(32'h0000_0008, 1'b0);
		queue_sample(32'h0000_0003, 1'b1);
		wait_drained();

		// A zero length behaves as a window of one.
		write_window_len('0);
		queue_sample(32'h8000_0000, 1'b0);
		queue_sample(32'h7fff_ffff, 1'b1);
		queue_sample(32'hffff_fffe, 1'b0);
		wait_drained();

		// An even window gives the lower of the two middle values.
		write_window_len(6'd2);
		queue_sample(32'h7fff_ffff, 1'b0);
		queue_sample(32'h8000_0000, 1'b0);
		queue_sample(32'h0000_0004, 1'b0);
		queue_sample(32'h0000_0004, 1'b0);
		queue_sample(32'hffff_fff0, 1'b0);
		wait_drained();

		// Random phases: receiver-heavy idling, then sender-heavy, then none.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p / 5)
				0: begin
					tx_idle_pct = 33;
					rx_idle_pct = 64;
				end
				1: begin
					tx_idle_pct = 64;
					rx_idle_pct = 33;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			write_window_len(WLEN_BITS'(phase_wlen[p]));
			n = (phase_wlen[p] >= 32) ? 2 * PHASE_SAMPLES : PHASE_SAMPLES;
			for (int i = 0; i < n; i++)
				queue_sample(random_sample(), $urandom_range(0, 39) == 0);
			// Stall the result side for a long stretch while samples keep coming.
			if (p % 5 == 0) begin
				repeat (4) @(posedge clk);
				holdoff_requests <= holdoff_requests + 1;
			end
			wait_drained();
		end

		if (expected_medians.size() != 0) begin
			$display("%0d predicted medians never arrived", expected_medians.size());
			error_count += expected_medians.size();
		end

		$display("Covered %0d samples and %0d medians over %0d window settings,",
			samples_accepted, medians_checked, settings_used);
		$display("including zero and oversized lengths, restarts and duplicate values.");
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
